### hdl/assert_macros.svh
// Assertion macros shared by the RTL of the radix digit converter.
// No dependencies; included by modules that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Checked property, disabled while reset is asserted
`define RDC_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Checked property that also holds during reset
`define RDC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RDC_ASSERT(lbl, clk, rstn, prop, msg)
`define RDC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

### hdl/rdc_pkg.sv
// Package for the radix digit converter: widths, radix limits and the
// structs between the sequencer and the bit-serial divider. No dependencies.
`default_nettype none

package rdc_pkg;

    // Input width and derived widths
    localparam int VALUE_WIDTH = 31;
    localparam int IDX_W       = $clog2(VALUE_WIDTH);
    localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);
    localparam int DIGIT_W     = 6;

    // Radix limits
    localparam logic [DIGIT_W-1:0] RADIX_MIN   = DIGIT_W'(2);
    localparam logic [DIGIT_W-1:0] RADIX_MAX   = DIGIT_W'(36);
    localparam logic [DIGIT_W-1:0] RADIX_RESET = DIGIT_W'(10);

    // Sequencer to divider
    typedef struct packed {
        logic                   start;
        logic [VALUE_WIDTH-1:0] dividend;
        logic [DIGIT_W-1:0]     radix;
    } t_div_ctrl;

    // Divider to sequencer
    typedef struct packed {
        logic                   done;
        logic [VALUE_WIDTH-1:0] quotient;
        logic [DIGIT_W-1:0]     remainder;
    } t_div_stat;

    // Clamp a raw register write into the supported radix range
    function automatic logic [DIGIT_W-1:0] clamp_radix(input logic [DIGIT_W-1:0] raw);
        logic [DIGIT_W-1:0] r;
        r = raw;
        if (raw < RADIX_MIN) begin
            r = RADIX_MIN;
        end else if (raw > RADIX_MAX) begin
            r = RADIX_MAX;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### hdl/rdc_if.sv
// Handshake interfaces of the radix digit converter: input value,
// result digits and radix register writes. Depends on rdc_pkg.
`default_nettype none

interface rdc_in_if import rdc_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic [VALUE_WIDTH-1:0] value;
    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface rdc_out_if import rdc_pkg::*;;
    logic               valid;
    logic               ready;
    logic [DIGIT_W-1:0] digit;
    logic               last;
    logic               error;
    modport source (output valid, output digit, output last, output error, input ready);
    modport sink   (input valid, input digit, input last, input error, output ready);
endinterface

interface rdc_cfg_if import rdc_pkg::*;;
    logic               valid;
    logic               ready;
    logic [DIGIT_W-1:0] radix;
    modport source (output valid, output radix, input ready);
    modport sink   (input valid, input radix, output ready);
endinterface

`default_nettype wire

### hdl/rdc_divider.sv
// Bit-serial restoring divider: one quotient bit per cycle, remainder < radix.
// Depends on rdc_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module rdc_divider import rdc_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_div_ctrl i_ctrl,
    output t_div_stat      o_stat
);

    logic                   r_busy;
    logic                   r_done;
    logic [IDX_W-1:0]       r_cnt;
    logic [VALUE_WIDTH-1:0] r_q;
    logic [DIGIT_W-1:0]     r_rem;
    logic [DIGIT_W-1:0]     r_rad;

    logic [DIGIT_W:0]       n_trial;
    logic                   n_bit;
    logic [DIGIT_W-1:0]     n_rem;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        n_trial = {r_rem, r_q[VALUE_WIDTH-1]};
        n_bit   = (n_trial >= {1'b0, r_rad});
        n_rem   = n_bit ? DIGIT_W'(n_trial - {1'b0, r_rad}) : n_trial[DIGIT_W-1:0];
    end

    // Quotient bits replace dividend bits in the same shift register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctrl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_q    <= i_ctrl.dividend;
                r_rem  <= '0;
                r_rad  <= i_ctrl.radix;
            end else if (r_busy) begin
                r_q   <= {r_q[VALUE_WIDTH-2:0], n_bit};
                r_rem <= n_rem;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == IDX_W'(VALUE_WIDTH - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.done      = r_done;
    assign o_stat.quotient  = r_q;
    assign o_stat.remainder = r_rem;

    `RDC_ASSERT(a_rem_below_radix, i_clk, i_rst_n, (r_busy || r_done) |-> (r_rem < r_rad),
        "divider remainder not below radix")
    `RDC_ASSERT(a_no_start_busy, i_clk, i_rst_n, i_ctrl.start |-> !r_busy,
        "divider restarted while busy")
    `RDC_ASSERT(a_done_ends_busy, i_clk, i_rst_n, $fell(r_busy) |-> r_done,
        "divider left busy without done")

endmodule

`default_nettype wire

### hdl/rdc_digit_stack.sv
// Digit stack memory: one write port, one registered read port.
// Depends on rdc_pkg.
`default_nettype none

module rdc_digit_stack import rdc_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_we,
    input  wire logic [IDX_W-1:0]   i_waddr,
    input  wire logic [DIGIT_W-1:0] i_wdata,
    input  wire logic               i_re,
    input  wire logic [IDX_W-1:0]   i_raddr,
    output logic      [DIGIT_W-1:0] o_rdata
);

    logic [DIGIT_W-1:0] r_mem [VALUE_WIDTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### hdl/radix_digit_converter.sv
// A value with D digits takes D bit-serial divisions (one quotient bit per cycle),
// then each digit is popped from the stack through S_RD and S_OUT.
// One item at a time: a new value is accepted only in S_IDLE.
// A zero input goes to S_ERR; its error result is loaded once the output register is free.
// Synchronous active-low reset clears control state and sets the radix to 10;
// the digit stack is not cleared. Radix writes are accepted in any cycle.
`default_nettype none
`include "assert_macros.svh"

module radix_digit_converter import rdc_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    rdc_in_if.sink    i_in,
    rdc_cfg_if.sink   i_cfg,
    rdc_out_if.source o_res
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_RD,
        S_OUT,
        S_ERR
    } t_state;

    t_state             r_state;
    logic [CNT_W-1:0]   r_count;
    logic [DIGIT_W-1:0] r_radix;
    logic               r_ovalid;
    logic [DIGIT_W-1:0] r_odigit;
    logic               r_olast;
    logic               r_oerr;

    t_div_ctrl          div_ctrl;
    t_div_stat          div_stat;
    logic [DIGIT_W-1:0] stack_rdata;
    logic               in_xfer;
    logic               out_free;
    logic               out_load;
    logic               div_more;
    logic               stack_re;
    logic [IDX_W-1:0]   top_idx;

    assign in_xfer  = i_in.valid && i_in.ready;
    assign out_free = !r_ovalid || o_res.ready;
    // Output register takes a new result this cycle
    assign out_load = out_free && (r_state inside {S_OUT, S_ERR});
    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign top_idx  = IDX_W'(r_count - 1'b1);
    assign stack_re = (r_state == S_RD);
    // Another division is needed while the quotient is nonzero and the stack has room
    assign div_more = (div_stat.quotient != '0) &&
                      (r_count != CNT_W'(VALUE_WIDTH - 1));

    // Divider start: from a new value, or chained on the previous quotient
    always_comb begin
        div_ctrl.radix = r_radix;
        if (r_state == S_DIV) begin
            div_ctrl.start    = div_stat.done && div_more;
            div_ctrl.dividend = div_stat.quotient;
        end else begin
            div_ctrl.start    = in_xfer && (i_in.value != '0);
            div_ctrl.dividend = i_in.value;
        end
    end

    rdc_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (div_ctrl),
        .o_stat  (div_stat)
    );

    rdc_digit_stack u_stack (
        .i_clk   (i_clk),
        .i_we    ((r_state == S_DIV) && div_stat.done),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (div_stat.remainder),
        .i_re    (stack_re),
        .i_raddr (top_idx),
        .o_rdata (stack_rdata)
    );

    // Radix register, clamped at write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_radix <= clamp_radix(i_cfg.radix);
        end
    end

    // Sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_count <= '0;
                        r_state <= (i_in.value == '0) ? S_ERR : S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_stat.done) begin
                        r_count <= r_count + 1'b1;
                        if (!div_more) begin
                            r_state <= S_RD;
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_odigit <= stack_rdata;
                        r_olast  <= (r_count == CNT_W'(1));
                        r_oerr   <= 1'b0;
                        r_count  <= r_count - 1'b1;
                        r_state  <= (r_count == CNT_W'(1)) ? S_IDLE : S_RD;
                    end
                end
                S_ERR: begin
                    if (out_free) begin
                        r_odigit <= '0;
                        r_olast  <= 1'b1;
                        r_oerr   <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_res.valid = r_ovalid;
    assign o_res.digit = r_odigit;
    assign o_res.last  = r_olast;
    assign o_res.error = r_oerr;

    `RDC_ASSERT(a_err_form, i_clk, i_rst_n,
        (r_ovalid && r_oerr) |-> (r_olast && (r_odigit == '0)),
        "error result must be last with digit zero")
    `RDC_ASSERT(a_count_range, i_clk, i_rst_n, r_count <= CNT_W'(VALUE_WIDTH),
        "digit count beyond stack depth")
    `RDC_ASSERT(a_pop_nonempty, i_clk, i_rst_n,
        (r_state == S_RD || r_state == S_OUT) |-> (r_count != '0),
        "pop from empty digit stack")
    `RDC_ASSERT(a_radix_range, i_clk, i_rst_n,
        (r_radix >= RADIX_MIN) && (r_radix <= RADIX_MAX),
        "radix register out of range")

endmodule

`default_nettype wire

### dv/tb_radix_digit_converter.sv
`timescale 1ns / 1ps
// Self-checking testbench for radix_digit_converter: directed and random values,
// radix register writes and random handshake pressure. Depends on rdc_pkg and rdc_if.

module tb_radix_digit_converter;
    import rdc_pkg::*;

    localparam int STALL_LIMIT = 8000;   // cycles without any transfer
    localparam longint unsigned VALUE_MAX = (64'd1 << VALUE_WIDTH) - 1;

    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic               last;
        logic               error;
    } t_digit_result;

    // Predicts the digit stream of each value and checks the block's results
    class t_digit_scoreboard;
        logic [DIGIT_W-1:0] radix_reg;
        t_digit_result      expected_digits[$];
        int                 failures;

        function new();
            radix_reg = RADIX_RESET;
            failures  = 0;
        endfunction

        function void set_radix(logic [DIGIT_W-1:0] raw);
            radix_reg = raw;
        endfunction

        // Out-of-range radix values saturate to the supported limits
        function int unsigned effective_base();
            if (radix_reg < RADIX_MIN) return RADIX_MIN;
            if (radix_reg > RADIX_MAX) return RADIX_MAX;
            return radix_reg;
        endfunction

        function int pending();
            return expected_digits.size();
        endfunction

        // Repeated division, then most significant digit first
        function void note_value(logic [VALUE_WIDTH-1:0] v);
            longint unsigned    q;
            int unsigned        base;
            logic [DIGIT_W-1:0] rems[$];
            t_digit_result      res;
            base = effective_base();
            q    = v;
            if (q == 0) begin
                res.digit = '0;
                res.last  = 1'b1;
                res.error = 1'b1;
                expected_digits.push_back(res);
                return;
            end
            while (q != 0) begin
                rems.push_back(DIGIT_W'(q % base));
                q = q / base;
            end
            for (int k = rems.size() - 1; k >= 0; k--) begin
                res.digit = rems[k];
                res.last  = (k == 0);
                res.error = 1'b0;
                expected_digits.push_back(res);
            end
        endfunction

        function void check_digit(logic [DIGIT_W-1:0] digit, logic last, logic error);
            t_digit_result exp_res;
            if (expected_digits.size() == 0) begin
                $error("unexpected result: digit %0d last %0b error %0b",
                       digit, last, error);
                failures++;
                return;
            end
            exp_res = expected_digits.pop_front();
            if (digit !== exp_res.digit) begin
                $error("digit: expected %0d, got %0d", exp_res.digit, digit);
                failures++;
            end
            if (last !== exp_res.last) begin
                $error("last: expected %0b, got %0b", exp_res.last, last);
                failures++;
            end
            if (error !== exp_res.error) begin
                $error("error: expected %0b, got %0b", exp_res.error, error);
                failures++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   sender_idle_pct;
    int   recv_stall_pct;
    int   quiet_cycles;

    rdc_in_if  value_if ();
    rdc_cfg_if radix_if ();
    rdc_out_if digit_if ();

    t_digit_scoreboard sb;

    radix_digit_converter dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (value_if),
        .i_cfg   (radix_if),
        .o_res   (digit_if)
    );

    // 4 ns clock
    initial clk = 1'b0;
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Receiver back-pressure
    always @(negedge clk) begin
        digit_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Observe every transfer at the rising edge
    always @(posedge clk) begin
        if (rst_n) begin
            if (radix_if.valid && radix_if.ready) begin
                sb.set_radix(radix_if.radix);
            end
            if (value_if.valid && value_if.ready) begin
                sb.note_value(value_if.value);
            end
            if (digit_if.valid && digit_if.ready) begin
                sb.check_digit(digit_if.digit, digit_if.last, digit_if.error);
            end
        end
        if ((value_if.valid && value_if.ready) || (digit_if.valid && digit_if.ready) ||
            (radix_if.valid && radix_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Watchdog
    initial begin
        while (quiet_cycles < STALL_LIMIT) @(posedge clk);
        $display("TEST FAILED");
        $finish;
    end

    // One value transfer; valid stays high on return so values can go back to back
    task automatic send_value(input logic [VALUE_WIDTH-1:0] v);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            value_if.valid <= 1'b0;
            @(negedge clk);
        end
        value_if.valid <= 1'b1;
        value_if.value <= v;
        do @(posedge clk); while (!value_if.ready);
        @(negedge clk);
    endtask

    // Stop sending and wait until every expected digit has come back
    task automatic drain();
        value_if.valid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
    endtask

    // Register write, only with the block idle
    task automatic write_radix(input logic [DIGIT_W-1:0] r);
        drain();
        radix_if.valid <= 1'b1;
        radix_if.radix <= r;
        do @(posedge clk); while (!radix_if.ready);
        @(negedge clk);
        radix_if.valid <= 1'b0;
    endtask

    // Half the writes in range, the rest anywhere in the 6-bit field
    function automatic logic [DIGIT_W-1:0] pick_radix();
        if ($urandom_range(0, 1) == 0) return DIGIT_W'($urandom_range(0, 63));
        return DIGIT_W'($urandom_range(RADIX_MIN, RADIX_MAX));
    endfunction

    // Zero, short values, powers of the base or one less, full width
    function automatic logic [VALUE_WIDTH-1:0] pick_value(input int unsigned base);
        longint unsigned p;
        int              k;
        p = 1;
        case ($urandom_range(0, 9))
            0: return '0;
            1, 2: return VALUE_WIDTH'($urandom_range(1, base * base));
            3, 4: begin
                k = $urandom_range(1, 30);
                repeat (k) if (p * base <= VALUE_MAX) p = p * base;
                if ($urandom_range(0, 1) == 1) p = p - 1;
                return VALUE_WIDTH'(p);
            end
            default: return VALUE_WIDTH'($urandom >> $urandom_range(0, 8));
        endcase
    endfunction

    initial begin
        int idle_mix[4];
        int stall_mix[4];
        sb = new();
        idle_mix  = '{0, 85, 0, 24};
        stall_mix = '{0, 0, 85, 24};
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        quiet_cycles    = 0;
        rst_n           = 1'b0;
        value_if.valid  = 1'b0;
        value_if.value  = '0;
        radix_if.valid  = 1'b0;
        radix_if.radix  = '0;
        digit_if.ready  = 1'b0;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: reset radix, zero input, extremes of value and radix
        send_value(VALUE_WIDTH'(0));
        send_value(VALUE_WIDTH'(1));
        send_value(VALUE_WIDTH'(9));
        send_value(VALUE_WIDTH'(10));
        send_value(VALUE_WIDTH'(VALUE_MAX));
        write_radix(RADIX_MIN);
        send_value(VALUE_WIDTH'(1));
        send_value(VALUE_WIDTH'(VALUE_MAX));
        send_value(VALUE_WIDTH'(64'd1 << (VALUE_WIDTH - 1)));
        write_radix(RADIX_MAX);
        send_value(VALUE_WIDTH'(35));
        send_value(VALUE_WIDTH'(36));
        send_value(VALUE_WIDTH'(1295));
        send_value(VALUE_WIDTH'(VALUE_MAX));
        // radix below two saturates to two
        write_radix(DIGIT_W'(0));
        send_value(VALUE_WIDTH'(5));
        write_radix(DIGIT_W'(1));
        send_value(VALUE_WIDTH'(6));
        // radix above thirty-six saturates to thirty-six
        write_radix(DIGIT_W'(37));
        send_value(VALUE_WIDTH'(1296));
        write_radix(DIGIT_W'(63));
        send_value(VALUE_WIDTH'(71));
        write_radix(DIGIT_W'(16));
        send_value(VALUE_WIDTH'(32'h5555_5555));
        write_radix(DIGIT_W'(3));
        send_value(VALUE_WIDTH'(32'h2AAA_AAAA));

        // Random values under each pressure mix, radix changed every few values
        for (int ph = 0; ph < 4; ph++) begin
            drain();
            sender_idle_pct = idle_mix[ph];
            recv_stall_pct  = stall_mix[ph];
            for (int grp = 0; grp < 5; grp++) begin
                write_radix(pick_radix());
                repeat (5) send_value(pick_value(sb.effective_base()));
            end
        end

        drain();
        recv_stall_pct = 0;
        repeat (40) @(negedge clk);
        if (sb.pending() != 0) begin
            $error("%0d expected digits never arrived", sb.pending());
        end
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
